// File: rtl/tbna_pkg.sv
// tbna_pkg: shared types and constants of the tree bitmap number allocator
// used by the interfaces, the control sequencer and the top level

package tbna_pkg;

   localparam int DEF_CAPACITY = 1024;

   localparam int REQ_W = 2;
   localparam int NUM_W = 10;
   localparam int CFG_W = 11;

   localparam logic [CFG_W-1:0] MAX_NUMBERS_RESET = 11'd1024;

   localparam logic [REQ_W-1:0] REQ_GET     = 2'd0;
   localparam logic [REQ_W-1:0] REQ_CHECK   = 2'd1;
   localparam logic [REQ_W-1:0] REQ_RELEASE = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_DESCEND,
      ST_ASCEND,
      ST_CHECK,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic [NUM_W-1:0] granted_number;
      logic             success;
      logic             out_of_range;
   } rsp_type;

endpackage

// File: rtl/tbna_ifc.sv
// tbna_ifc: valid/ready channel interfaces for requests and responses
// depends on tbna_pkg for the field widths

interface tbna_req_if import tbna_pkg::*;;
   logic             valid;
   logic             ready;
   logic [REQ_W-1:0] req_type;
   logic [NUM_W-1:0] number;

   modport source (output valid, output req_type, output number, input ready);
   modport sink (input valid, input req_type, input number, output ready);
endinterface

interface tbna_rsp_if import tbna_pkg::*;;
   logic             valid;
   logic             ready;
   logic [NUM_W-1:0] granted_number;
   logic             success;
   logic             out_of_range;

   modport source (output valid, output granted_number, output success,
                   output out_of_range, input ready);
   modport sink (input valid, input granted_number, input success,
                 input out_of_range, output ready);
endinterface

// File: rtl/tbna_tree_mem.sv
// tbna_tree_mem: one-bit node memory of the summary tree, heap order from 1
// one write port and one read port with registered read data

module tbna_tree_mem #(
   parameter int AW = 11
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic          wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic          rd_data
);

   logic tree_ff [2**AW];
   logic rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tree_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= tree_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/tbna_init.sv
// tbna_init: rebuild sweep that writes every tree node after reset or a count write
// a node is free when the first leaf under it lies below the active count

module tbna_init import tbna_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY,
   localparam int LW = $clog2(CAPACITY),
   localparam int AW = LW + 1,
   localparam int CW = (AW > CFG_W) ? AW : CFG_W
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [CW-1:0] active_count,
   output logic          busy,
   output logic          wr_en,
   output logic [AW-1:0] wr_addr,
   output logic          wr_data
);

   localparam logic [AW-1:0] LEAF_SPAN = AW'(2**LW);
   localparam logic [AW-1:0] LAST_NODE = '1;

   logic          busy_ff, busy_in;
   logic [AW-1:0] node_ff, node_in;
   logic [AW-1:0] first_ff, first_in;
   logic [AW-1:0] step_ff, step_in;
   logic [AW-1:0] first_next;

   assign first_next = first_ff + step_ff;

   always_comb begin
      busy_in  = busy_ff;
      node_in  = node_ff;
      first_in = first_ff;
      step_in  = step_ff;
      if (start) begin
         busy_in  = 1'b1;
         node_in  = AW'(1);
         first_in = '0;
         step_in  = LEAF_SPAN;
      end else if (busy_ff) begin
         node_in = node_ff + AW'(1);
         if (node_ff == LAST_NODE) begin
            busy_in = 1'b0;
         end
         // end of a tree level: next level starts at leaf 0 with half the span
         if (first_next == LEAF_SPAN) begin
            first_in = '0;
            step_in  = step_ff >> 1;
         end else begin
            first_in = first_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b1;
         node_ff  <= AW'(1);
         first_ff <= '0;
         step_ff  <= LEAF_SPAN;
      end else begin
         busy_ff  <= busy_in;
         node_ff  <= node_in;
         first_ff <= first_in;
         step_ff  <= step_in;
      end
   end

   assign busy    = busy_ff;
   assign wr_en   = busy_ff && !start;
   assign wr_addr = node_ff;
   assign wr_data = CW'(first_ff) < active_count;

endmodule

// File: rtl/tbna_ctrl.sv
// tbna_ctrl: request sequencer that walks the tree through the node memory port
// descends for get, reads one leaf for check, climbs ancestors after get or release

module tbna_ctrl import tbna_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY,
   localparam int LW = $clog2(CAPACITY),
   localparam int AW = LW + 1,
   localparam int CW = (AW > CFG_W) ? AW : CFG_W
) (
   input  logic          clock,
   input  logic          reset,
   tbna_req_if.sink      req,
   tbna_rsp_if.source    rsp,
   input  logic          init_busy,
   input  logic          csr_wr_en,
   input  logic [CW-1:0] active_count,
   output logic          mem_we,
   output logic [AW-1:0] mem_waddr,
   output logic          mem_wdata,
   output logic [AW-1:0] mem_raddr,
   input  logic          mem_rdata
);

   localparam logic [AW-1:0] ROOT_NODE = AW'(1);

   ctrl_state_type state_ff, state_in;
   logic [AW-1:0]  node_ff, node_in;
   logic           bit_ff, bit_in;
   rsp_type        res_ff, res_in;
   logic           rsp_valid_ff, rsp_valid_in;
   rsp_type        rsp_data_ff, rsp_data_in;

   logic           accept;
   logic [CW-1:0]  num_ext;
   logic           in_range;
   logic [AW-1:0]  num_node;
   logic [AW-1:0]  child;
   logic [AW-1:0]  parent;
   logic [CW-1:0]  leaf_ext;
   logic           out_free;

   assign req.ready = (state_ff == ST_IDLE) && !init_busy && !csr_wr_en;
   assign accept    = req.valid && req.ready;
   assign num_ext   = CW'(req.number);
   assign in_range  = num_ext < active_count;
   assign num_node  = {1'b1, num_ext[LW-1:0]};
   // left child when it holds a free number, else right child
   assign child     = {node_ff[LW-1:0], ~mem_rdata};
   assign parent    = {1'b0, node_ff[AW-1:1]};
   assign leaf_ext  = CW'(child[LW-1:0]);
   assign out_free  = !rsp_valid_ff || rsp.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req.req_type)
                  REQ_GET:     state_in = ST_ROOT;
                  REQ_CHECK:   state_in = in_range ? ST_CHECK : ST_DONE;
                  REQ_RELEASE: state_in = in_range ? ST_ASCEND : ST_DONE;
                  default:     state_in = ST_DONE;
               endcase
            end
         end
         ST_ROOT:    state_in = mem_rdata ? ST_DESCEND : ST_DONE;
         ST_DESCEND: state_in = child[LW] ? ST_ASCEND : ST_DESCEND;
         ST_ASCEND:  state_in = (parent == ROOT_NODE) ? ST_DONE : ST_ASCEND;
         ST_CHECK:   state_in = ST_DONE;
         ST_DONE:    state_in = out_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // memory port, walk registers and result
   always_comb begin
      mem_we       = 1'b0;
      mem_waddr    = node_ff;
      mem_wdata    = bit_ff;
      mem_raddr    = node_ff;
      node_in      = node_ff;
      bit_in       = bit_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_data_in  = rsp_data_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_in = '0;
               unique case (req.req_type)
                  REQ_GET: begin
                     mem_raddr = ROOT_NODE;
                  end
                  REQ_CHECK: begin
                     res_in.out_of_range = !in_range;
                     mem_raddr           = num_node;
                  end
                  REQ_RELEASE: begin
                     res_in.out_of_range = !in_range;
                     res_in.success      = in_range;
                     mem_we              = in_range;
                     mem_waddr           = num_node;
                     mem_wdata           = 1'b1;
                     mem_raddr           = {num_node[AW-1:1], ~num_node[0]};
                     node_in             = num_node;
                     bit_in              = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_ROOT: begin
            node_in   = ROOT_NODE;
            mem_raddr = {ROOT_NODE[LW-1:0], 1'b0};
         end
         ST_DESCEND: begin
            node_in = child;
            if (child[LW]) begin
               // leaf reached: take it and start the climb with its sibling
               mem_we                = 1'b1;
               mem_waddr             = child;
               mem_wdata             = 1'b0;
               mem_raddr             = {child[AW-1:1], ~child[0]};
               bit_in                = 1'b0;
               res_in.granted_number = leaf_ext[NUM_W-1:0];
               res_in.success        = 1'b1;
            end else begin
               mem_raddr = {child[LW-1:0], 1'b0};
            end
         end
         ST_ASCEND: begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            mem_wdata = bit_ff | mem_rdata;
            bit_in    = bit_ff | mem_rdata;
            node_in   = parent;
            mem_raddr = {parent[AW-1:1], ~parent[0]};
         end
         ST_CHECK: begin
            res_in.success = mem_rdata;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      node_ff     <= node_in;
      bit_ff      <= bit_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.granted_number = rsp_data_ff.granted_number;
   assign rsp.success        = rsp_data_ff.success;
   assign rsp.out_of_range   = rsp_data_ff.out_of_range;

endmodule

// File: rtl/tree_bitmap_number_allocator.sv
// tree_bitmap_number_allocator: top level of the free number allocator
// depends on tbna_pkg, tbna_ifc, tbna_tree_mem, tbna_init and tbna_ctrl
//
// Hands out the lowest free number below max_numbers (at most the capacity),
// checks and releases numbers. Free numbers are leaves of a one-bit OR tree
// held in one memory. req_chan takes one transaction (get, check or release)
// when valid and ready are high; rsp_chan returns exactly one result
// transaction for each. Requests are taken one at a time; ready is high only
// while no request is in work and no rebuild runs. A get reads the root and,
// if a number is free, descends to the lowest free leaf and climbs its
// ancestors; a check reads one leaf; a release writes its leaf and climbs; an
// out-of-range check or release, or an unused code, goes straight to the result.
// One tree level is visited per cycle through the single memory read port.
// The result register lets the next request enter while a result still waits;
// a stalled receiver holds the sequencer only when a second result is ready.
// Reset and every csr write start a rebuild of all 2*P-1 tree nodes (2047
// by default) during which no request is taken.

module tree_bitmap_number_allocator import tbna_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   tbna_req_if.sink         req_chan,
   tbna_rsp_if.source       rsp_chan,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data
);

   localparam int LW = $clog2(CAPACITY);
   localparam int AW = LW + 1;
   localparam int CW = (AW > CFG_W) ? AW : CFG_W;

   logic [CFG_W-1:0] max_numbers_ff, max_numbers_in;
   logic [CW-1:0]    count_ext;
   logic [CW-1:0]    active_count;

   logic          init_busy;
   logic          init_we;
   logic [AW-1:0] init_waddr;
   logic          init_wdata;

   logic          ctrl_we;
   logic [AW-1:0] ctrl_waddr;
   logic          ctrl_wdata;
   logic [AW-1:0] ctrl_raddr;

   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic          mem_wdata;
   logic          mem_rdata;

   assign max_numbers_in = csr_wr_en ? csr_wr_data : max_numbers_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_numbers_ff <= MAX_NUMBERS_RESET;
      end else begin
         max_numbers_ff <= max_numbers_in;
      end
   end

   // count saturates at the capacity
   assign count_ext    = CW'(max_numbers_ff);
   assign active_count = (count_ext > CW'(CAPACITY)) ? CW'(CAPACITY) : count_ext;

   tbna_init #(
      .CAPACITY (CAPACITY)
   ) u_init (
      .clock        (clock),
      .reset        (reset),
      .start        (csr_wr_en),
      .active_count (active_count),
      .busy         (init_busy),
      .wr_en        (init_we),
      .wr_addr      (init_waddr),
      .wr_data      (init_wdata)
   );

   tbna_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req          (req_chan),
      .rsp          (rsp_chan),
      .init_busy    (init_busy),
      .csr_wr_en    (csr_wr_en),
      .active_count (active_count),
      .mem_we       (ctrl_we),
      .mem_waddr    (ctrl_waddr),
      .mem_wdata    (ctrl_wdata),
      .mem_raddr    (ctrl_raddr),
      .mem_rdata    (mem_rdata)
   );

   assign mem_we    = init_busy ? init_we : ctrl_we;
   assign mem_waddr = init_busy ? init_waddr : ctrl_waddr;
   assign mem_wdata = init_busy ? init_wdata : ctrl_wdata;

   tbna_tree_mem #(
      .AW (AW)
   ) u_tree_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (ctrl_raddr),
      .rd_data (mem_rdata)
   );

`ifndef ASSERT_OFF
   // a count write starts a rebuild, so no request may enter next cycle
   a_csr_blocks_req: assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> !req_chan.ready)
      else $error("request taken during tree rebuild");

   // a result never reports both success and out of range
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !(rsp_chan.success && rsp_chan.out_of_range))
      else $error("success and out_of_range both set");

   // a nonzero granted number only comes with success
   a_grant_success: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && (rsp_chan.granted_number != '0)) |-> rsp_chan.success)
      else $error("granted number without success");

   // the sequencer never writes the tree while the rebuild owns it
   a_no_ctrl_write: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !ctrl_we)
      else $error("sequencer write during rebuild");
`endif

endmodule

// File: tb/tbna_checker.sv
// tbna_checker: watches the request, response and csr ports of the allocator,
// predicts every response and compares it field by field
// depends on tbna_pkg and the channel interfaces in tbna_ifc

module tbna_checker import tbna_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic             clock,
   input  logic             reset,
   tbna_req_if              req_mon,
   tbna_rsp_if              rsp_mon,
   input  logic             csr_wr_en,
   input  logic [CFG_W-1:0] csr_wr_data,
   output int               pending,
   output int               fail_count
);

   logic [CAPACITY-1:0] free_map;
   int unsigned         active_count;
   rsp_type             expected_q[$];
   int                  mismatches = 0;

   // count saturates at capacity, everything at or above it is taken
   function automatic void rebuild_store(input logic [CFG_W-1:0] value);
      active_count = (value > CAPACITY) ? CAPACITY : value;
      free_map = '0;
      for (int k = 0; k < active_count; k++)
         free_map[k] = 1'b1;
   endfunction

   function automatic rsp_type apply_request(input logic [REQ_W-1:0] kind,
                                             input logic [NUM_W-1:0] num);
      rsp_type r;
      int      lowest;
      r = '0;
      lowest = -1;
      case (kind)
         REQ_GET: begin
            for (int k = CAPACITY - 1; k >= 0; k--)
               if (free_map[k]) lowest = k;
            if (lowest >= 0) begin
               free_map[lowest] = 1'b0;
               r.granted_number = lowest[NUM_W-1:0];
               r.success = 1'b1;
            end
         end
         REQ_CHECK, REQ_RELEASE: begin
            if (num >= active_count) begin
               r.out_of_range = 1'b1;
            end else if (kind == REQ_CHECK) begin
               r.success = free_map[num];
            end else begin
               free_map[num] = 1'b1;
               r.success = 1'b1;
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rebuild_store(MAX_NUMBERS_RESET);
         expected_q.delete();
      end else begin
         if (csr_wr_en) rebuild_store(csr_wr_data);
         if (req_mon.valid && req_mon.ready)
            expected_q.push_back(apply_request(req_mon.req_type, req_mon.number));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               $error("response transaction with no request outstanding");
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_mon.granted_number !== want.granted_number) begin
                  $error("granted_number: expected %0d, got %0d",
                         want.granted_number, rsp_mon.granted_number);
                  mismatches++;
               end
               if (rsp_mon.success !== want.success) begin
                  $error("success: expected %0d, got %0d",
                         want.success, rsp_mon.success);
                  mismatches++;
               end
               if (rsp_mon.out_of_range !== want.out_of_range) begin
                  $error("out_of_range: expected %0d, got %0d",
                         want.out_of_range, rsp_mon.out_of_range);
                  mismatches++;
               end
            end
         end
      end
      pending <= expected_q.size();
      fail_count <= mismatches;
   end

endmodule

// File: tb/tb.sv
// tb: drives gets, checks and releases into the allocator under several count
// settings and idling patterns, and reports the verdict
// depends on tbna_pkg, tbna_ifc, tbna_checker and the allocator top level

module tb;
   import tbna_pkg::*;

   localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RANDOM_PHASES   = 10;
   localparam int ITEMS_PER_PHASE = 55;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en;
   logic [CFG_W-1:0] csr_wr_data;
   int               pending;
   int               fail_count;
   int               cycle_count = 0;
   int               sender_idle_pct = 0;
   int               recv_stall_pct = 0;
   int               active_n = DEF_CAPACITY;

   logic [CFG_W-1:0] phase_cfg [RANDOM_PHASES] = '{
      11'd2047, 11'd5, 11'd1024, 11'd1, 11'd700, 11'd64, 11'd0, 11'd1023, 11'd0, 11'd2
   };

   tbna_req_if req_chan ();
   tbna_rsp_if rsp_chan ();

   tree_bitmap_number_allocator dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   tbna_checker #(.CAPACITY(DEF_CAPACITY)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .pending     (pending),
      .fail_count  (fail_count)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL tree_bitmap_number_allocator");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall_pct);

   // valid stays high across back-to-back transactions
   task automatic send_request(input logic [REQ_W-1:0] kind, input logic [NUM_W-1:0] num);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.number   <= num;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   task automatic write_max_numbers(input logic [CFG_W-1:0] value);
      wait_drained();
      while (!req_chan.ready) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      active_n = (value > DEF_CAPACITY) ? DEF_CAPACITY : value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_idling(input int mode);
      case (mode)
         0: begin sender_idle_pct = 0;  recv_stall_pct <= 0;  end
         1: begin sender_idle_pct = 83; recv_stall_pct <= 0;  end
         2: begin sender_idle_pct = 0;  recv_stall_pct <= 83; end
         default: begin sender_idle_pct = 20; recv_stall_pct <= 20; end
      endcase
   endtask

   task automatic send_random_item();
      logic [REQ_W-1:0] kind;
      logic [NUM_W-1:0] num;
      int               roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) kind = REQ_GET;
      else if (roll < 70) kind = REQ_RELEASE;
      else if (roll < 95) kind = REQ_CHECK;
      else kind = REQ_UNUSED;
      // mostly aim inside the managed range, sometimes anywhere
      if (active_n > 0 && $urandom_range(0, 99) < 85)
         num = NUM_W'($urandom_range(0, active_n - 1));
      else
         num = NUM_W'($urandom_range(0, 1023));
      send_request(kind, num);
   endtask

   initial begin
      logic [CFG_W-1:0] cfg;
      req_chan.valid    = 1'b0;
      req_chan.req_type = REQ_GET;
      req_chan.number   = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // full range after reset
      send_request(REQ_GET, 10'd0);
      send_request(REQ_GET, 10'd1023);
      send_request(REQ_CHECK, 10'd0);
      send_request(REQ_CHECK, 10'd1023);
      send_request(REQ_RELEASE, 10'd0);
      send_request(REQ_GET, 10'd0);
      send_request(REQ_RELEASE, 10'd1023);
      send_request(REQ_UNUSED, 10'd1023);
      send_request(REQ_RELEASE, 10'd1);
      send_request(REQ_CHECK, 10'd1);

      // single number: exhaust it, then out of range above it
      write_max_numbers(11'd1);
      send_request(REQ_GET, 10'd0);
      send_request(REQ_GET, 10'd0);
      send_request(REQ_CHECK, 10'd0);
      send_request(REQ_CHECK, 10'd1);
      send_request(REQ_RELEASE, 10'd1023);
      send_request(REQ_RELEASE, 10'd0);
      send_request(REQ_CHECK, 10'd0);

      // empty store
      write_max_numbers(11'd0);
      send_request(REQ_GET, 10'd0);
      send_request(REQ_CHECK, 10'd0);
      send_request(REQ_RELEASE, 10'd0);

      // count above capacity saturates
      write_max_numbers(11'd2047);
      send_request(REQ_CHECK, 10'd1023);
      send_request(REQ_GET, 10'd1023);
      send_request(REQ_UNUSED, 10'd0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == 8) cfg = CFG_W'($urandom_range(1, 1100));
         else cfg = phase_cfg[phase];
         write_max_numbers(cfg);
         set_idling(phase % 4);
         for (int k = 0; k < ITEMS_PER_PHASE; k++)
            send_random_item();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("PASS tree_bitmap_number_allocator");
      else
         $display("FAIL tree_bitmap_number_allocator");
      $finish;
   end

endmodule

// File: filelist.f
rtl/tbna_pkg.sv
rtl/tbna_ifc.sv
rtl/tbna_tree_mem.sv
rtl/tbna_init.sv
rtl/tbna_ctrl.sv
rtl/tree_bitmap_number_allocator.sv
tb/tbna_checker.sv
tb/tb.sv
